/* hdl/crsd_pkg.sv */
`timescale 1ns / 1ps

package crsd_pkg;

  localparam int unsigned STAGES_DEF          = 19;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  localparam int unsigned VEC_W           = 16;
  localparam int unsigned ANGLE_W         = 26;
  localparam int unsigned OUT_W           = 17;
  localparam int unsigned GUARD_BITS      = 16;
  localparam int unsigned XY_W            = VEC_W + GUARD_BITS + 3;
  localparam int unsigned GAIN_W          = 17;
  localparam int unsigned GAIN_Q16        = 39800;
  localparam int unsigned OUT_LIMIT       = 46341;
  localparam int unsigned TABLE_LEN       = 24;
  localparam int unsigned TABLE_FRAC_BITS = 20;

  typedef logic signed [XY_W-1:0] xy_t;

  localparam logic [25:0] ATAN_Q20 [TABLE_LEN] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
    26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
    26'd234682,   26'd117342,   26'd58671,    26'd29335,
    26'd14668,    26'd7334,     26'd3667,     26'd1833,
    26'd917,      26'd458,      26'd229,      26'd115,
    26'd57,       26'd29,       26'd14,       26'd7
  };

  // Arctangent of 2^-j in units of 2^-f degree, rounded half up.
  function automatic logic [63:0] atan_angle(input int unsigned j, input int unsigned f);
    logic [63:0] t;
    int unsigned d;
    t = 64'(ATAN_Q20[5'(j)]);
    if (f >= TABLE_FRAC_BITS) begin
      return t << (f - TABLE_FRAC_BITS);
    end
    d = TABLE_FRAC_BITS - f;
    return (t + (64'd1 << (d - 1))) >> d;
  endfunction

  // Signed width of the residual angle, which stays within plus or minus 90 degrees.
  function automatic int unsigned z_width(input int unsigned f);
    return int'($clog2((64'd90 << f) + 64'd1)) + 2;
  endfunction

endpackage

/* hdl/crsd_stage.sv */
`timescale 1ns / 1ps

module crsd_stage #(
  parameter int unsigned J               = 0,
  parameter int unsigned ANGLE_FRAC_BITS = crsd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned ZW              = crsd_pkg::z_width(crsd_pkg::ANGLE_FRAC_BITS_DEF)
) (
  input  logic                  clk,
  input  logic                  load,
  input  crsd_pkg::xy_t         x_i,
  input  crsd_pkg::xy_t         y_i,
  input  logic signed [ZW-1:0]  z_i,
  output crsd_pkg::xy_t         x_r,
  output crsd_pkg::xy_t         y_r,
  output logic signed [ZW-1:0]  z_r
);

  localparam logic [63:0]       ANG64 = crsd_pkg::atan_angle(J, ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] ANG = ZW'(ANG64);

  crsd_pkg::xy_t         xs;
  crsd_pkg::xy_t         ys;
  crsd_pkg::xy_t         x_nxt;
  crsd_pkg::xy_t         y_nxt;
  logic signed [ZW-1:0]  z_nxt;

  always_comb begin
    xs = x_i >>> J;
    ys = y_i >>> J;
    if (z_i[ZW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

/* hdl/cordic_rotate_sine_degrees.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_vec_x, in_vec_y, in_angle_deg
// out_      output     out_valid / out_stall out_rotated_y
//
// One transaction enters per cycle while in_stall is low. Registered steps: the RS
// compare-subtract steps of the modulo 360 reduction (2 at 16 angle fraction bits),
// the quadrant fold, STAGES rotation stages (19 by default), gain product, output.
// Reset is synchronous and clears only the valid bits.
// A stalled output is held; one more result is caught in a skid register, after
// which the whole pipeline freezes and in_stall is raised until it drains.

module cordic_rotate_sine_degrees #(
  parameter int unsigned STAGES          = crsd_pkg::STAGES_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = crsd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [crsd_pkg::VEC_W-1:0]   in_vec_x,
  input  logic signed [crsd_pkg::VEC_W-1:0]   in_vec_y,
  input  logic [crsd_pkg::ANGLE_W-1:0]        in_angle_deg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [crsd_pkg::OUT_W-1:0]   out_rotated_y
);

  localparam int unsigned VW   = crsd_pkg::VEC_W;
  localparam int unsigned AW   = crsd_pkg::ANGLE_W;
  localparam int unsigned OW   = crsd_pkg::OUT_W;
  localparam int unsigned G    = crsd_pkg::GUARD_BITS;
  localparam int unsigned XYW  = crsd_pkg::XY_W;
  localparam int unsigned ZW   = crsd_pkg::z_width(ANGLE_FRAC_BITS);
  localparam int unsigned PW   = XYW + crsd_pkg::GAIN_W;
  localparam int unsigned RW   = PW - (G + 16);
  localparam int unsigned PADW = XYW - VW - 1 - G;

  localparam logic [63:0] MOD_BASE = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [63:0] QMAX     = ((64'd1 << AW) - 64'd1) / MOD_BASE;
  localparam int unsigned RS_RAW   = $clog2(QMAX + 64'd1);
  localparam int unsigned RS       = (RS_RAW < 1) ? 1 : RS_RAW;
  localparam int unsigned P        = RS + STAGES + 2;
  localparam int unsigned POS_FOLD = RS;
  localparam int unsigned POS_MUL  = P - 1;

  localparam logic [63:0] Q90  = 64'd90 << ANGLE_FRAC_BITS;
  localparam logic [63:0] Q180 = 64'd180 << ANGLE_FRAC_BITS;
  localparam logic [63:0] Q270 = 64'd270 << ANGLE_FRAC_BITS;

  localparam logic signed [crsd_pkg::GAIN_W-1:0] GAIN = crsd_pkg::GAIN_W'(crsd_pkg::GAIN_Q16);
  localparam logic signed [PW-1:0] RND = PW'(64'd1 << (G + 15));
  localparam logic signed [RW-1:0] LIM = RW'(crsd_pkg::OUT_LIMIT);

  logic                   en;
  logic [P-1:0]           vld_r;
  logic [P-1:0]           vin;

  logic [AW-1:0]          red_r   [RS];
  logic [AW-1:0]          red_in  [RS];
  logic [AW-1:0]          red_nxt [RS];
  logic signed [VW-1:0]   rx_r    [RS];
  logic signed [VW-1:0]   ry_r    [RS];
  logic signed [VW-1:0]   rx_in   [RS];
  logic signed [VW-1:0]   ry_in   [RS];

  logic signed [VW:0]     fxe;
  logic signed [VW:0]     fye;
  logic signed [VW:0]     fx0;
  logic signed [VW:0]     fy0;
  logic [63:0]            ph;
  logic [63:0]            off;
  crsd_pkg::xy_t          fx_nxt;
  crsd_pkg::xy_t          fy_nxt;
  logic signed [ZW-1:0]   fz_nxt;
  crsd_pkg::xy_t          fx_r;
  crsd_pkg::xy_t          fy_r;
  logic signed [ZW-1:0]   fz_r;

  crsd_pkg::xy_t          cx [STAGES+1];
  crsd_pkg::xy_t          cy [STAGES+1];
  logic signed [ZW-1:0]   cz [STAGES+1];

  logic signed [PW-1:0]   prod_nxt;
  logic signed [PW-1:0]   prod_r;
  logic signed [PW-1:0]   rsum;
  logic signed [PW-1:0]   rsh;
  logic signed [RW-1:0]   rval;
  logic signed [OW-1:0]   res_nxt;

  logic                   arrive;
  logic                   take;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  logic signed [OW-1:0]   out_dat_r;
  logic signed [OW-1:0]   out_dat_nxt;
  logic                   skid_vld_r;
  logic                   skid_vld_nxt;
  logic signed [OW-1:0]   skid_dat_r;
  logic signed [OW-1:0]   skid_dat_nxt;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign vin      = {vld_r[P-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vin;
    end
  end

  always_comb begin
    for (int p = 0; p < RS; p++) begin
      if (p == 0) begin
        red_in[p] = in_angle_deg;
        rx_in[p]  = in_vec_x;
        ry_in[p]  = in_vec_y;
      end else begin
        red_in[p] = red_r[p-1];
        rx_in[p]  = rx_r[p-1];
        ry_in[p]  = ry_r[p-1];
      end
      if (64'(red_in[p]) >= (MOD_BASE << (RS - 1 - p))) begin
        red_nxt[p] = AW'(64'(red_in[p]) - (MOD_BASE << (RS - 1 - p)));
      end else begin
        red_nxt[p] = red_in[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < RS; p++) begin
      if (en && vin[p]) begin
        red_r[p] <= red_nxt[p];
        rx_r[p]  <= rx_in[p];
        ry_r[p]  <= ry_in[p];
      end
    end
  end

  always_comb begin
    fxe = {rx_r[RS-1][VW-1], rx_r[RS-1]};
    fye = {ry_r[RS-1][VW-1], ry_r[RS-1]};
    ph  = 64'(red_r[RS-1]);
    if (ph <= Q90) begin
      fx0 = fxe;
      fy0 = fye;
      off = 64'd0;
    end else if (ph <= Q180) begin
      fx0 = -fye;
      fy0 = fxe;
      off = Q90;
    end else if (ph <= Q270) begin
      fx0 = -fxe;
      fy0 = -fye;
      off = Q180;
    end else begin
      fx0 = fye;
      fy0 = -fxe;
      off = Q270;
    end
    fx_nxt = {{PADW{fx0[VW]}}, fx0, {G{1'b0}}};
    fy_nxt = {{PADW{fy0[VW]}}, fy0, {G{1'b0}}};
    fz_nxt = ZW'(ph - off);
  end

  always_ff @(posedge clk) begin
    if (en && vin[POS_FOLD]) begin
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      fz_r <= fz_nxt;
    end
  end

  assign cx[0] = fx_r;
  assign cy[0] = fy_r;
  assign cz[0] = fz_r;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    crsd_stage #(
      .J               (j),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .ZW              (ZW)
    ) u_stage (
      .clk  (clk),
      .load (en && vin[POS_FOLD+1+j]),
      .x_i  (cx[j]),
      .y_i  (cy[j]),
      .z_i  (cz[j]),
      .x_r  (cx[j+1]),
      .y_r  (cy[j+1]),
      .z_r  (cz[j+1])
    );
  end

  assign prod_nxt = cy[STAGES] * GAIN;

  always_ff @(posedge clk) begin
    if (en && vin[POS_MUL]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    rsum = prod_r + RND;
    rsh  = rsum >>> (G + 16);
    rval = rsh[RW-1:0];
    if (rval > LIM) begin
      res_nxt = OW'(LIM);
    end else if (rval < -LIM) begin
      res_nxt = OW'(-LIM);
    end else begin
      res_nxt = rval[OW-1:0];
    end
  end

  assign arrive = en && vld_r[P-1];
  assign take   = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = arrive;
        out_dat_nxt  = res_nxt;
      end
    end else if (arrive) begin
      skid_vld_nxt = 1'b1;
      skid_dat_nxt = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_rotated_y = out_dat_r;

endmodule

/* hdl/crsd_checker.sv */
`timescale 1ns / 1ps

module crsd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [crsd_pkg::VEC_W-1:0]   in_vec_x,
  input logic signed [crsd_pkg::VEC_W-1:0]   in_vec_y,
  input logic [crsd_pkg::ANGLE_W-1:0]        in_angle_deg,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [crsd_pkg::OUT_W-1:0]   out_rotated_y
);

  localparam logic signed [crsd_pkg::OUT_W-1:0] LIM = crsd_pkg::OUT_W'(crsd_pkg::OUT_LIMIT);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rotated_y))
    else $error("stalled result changed or vanished");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rotated_y <= LIM) && (out_rotated_y >= -LIM))
    else $error("result outside the clamp range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

endmodule

bind cordic_rotate_sine_degrees crsd_checker u_crsd_checker (.*);

/* tb/tb_cordic_rotate_sine_degrees.sv */
`timescale 1ns / 1ps

module tb_cordic_rotate_sine_degrees;

  localparam longint DEG90      = 64'd90 << 16;
  localparam longint DEG360     = 64'd360 << 16;
  localparam longint CLAMP      = 46341;
  localparam int     IDLE_LIMIT = 2000;
  localparam int     RANDOM_N   = 450;
  localparam int     DRAIN_WAIT = 40;

  localparam longint ATAN_DEG_Q20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [crsd_pkg::VEC_W-1:0] x;
    logic signed [crsd_pkg::VEC_W-1:0] y;
    logic [crsd_pkg::ANGLE_W-1:0]      ang;
    logic                              typed;
    logic signed [crsd_pkg::OUT_W-1:0] y_out;
  } sine_case_t;

  localparam int N_CASES = 21;

  sine_case_t sine_cases [N_CASES] = '{
    '{16'sd0,      16'sd0,      26'd0,        1'b1, 17'sd0},
    '{16'sd0,      16'sd0,      26'd67108863, 1'b1, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd0,        1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd5898240,  1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd11796480, 1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd17694720, 1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd23592960, 1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd5898241,  1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd11796481, 1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd17694721, 1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd2949120,  1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd1740967,  1'b0, 17'sd0},
    '{16'sd32767,  16'sd0,      26'd919883,   1'b0, 17'sd0},
    '{-16'sd32768, -16'sd32768, 26'd14745600, 1'b1, 17'sd46341},
    '{-16'sd32768, -16'sd32768, 26'd2949120,  1'b1, -17'sd46341},
    '{16'sd32767,  16'sd32767,  26'd47185920, 1'b0, 17'sd0},
    '{-16'sd32768, 16'sd32767,  26'd23592959, 1'b0, 17'sd0},
    '{16'sd0,      -16'sd32768, 26'd8847360,  1'b0, 17'sd0},
    '{16'sd1,      -16'sd1,     26'd1,        1'b0, 17'sd0},
    '{-16'sd1,     16'sd0,      26'd67108863, 1'b0, 17'sd0},
    '{16'sd32767,  -16'sd32768, 26'd20643840, 1'b0, 17'sd0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [crsd_pkg::VEC_W-1:0] in_vec_x;
  logic signed [crsd_pkg::VEC_W-1:0] in_vec_y;
  logic [crsd_pkg::ANGLE_W-1:0]      in_angle_deg;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [crsd_pkg::OUT_W-1:0] out_rotated_y;

  logic signed [crsd_pkg::OUT_W-1:0] pending_y [$];
  int  sent_count;
  int  checked_count;
  int  clamped_count;
  int  fault_count;
  int  idle_cycles;
  bit  in_burst;
  bit  out_burst;

  cordic_rotate_sine_degrees i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rotated_y(out_rotated_y)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [crsd_pkg::OUT_W-1:0] cordic_sine(
    input logic signed [crsd_pkg::VEC_W-1:0] vx,
    input logic signed [crsd_pkg::VEC_W-1:0] vy,
    input logic [crsd_pkg::ANGLE_W-1:0]      ang
  );
    longint phase;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint step;
    longint r;
    phase = longint'(ang) % DEG360;
    if (phase <= DEG90) begin
      x = longint'(vx);
      y = longint'(vy);
      z = phase;
    end else if (phase <= 2 * DEG90) begin
      x = -longint'(vy);
      y = longint'(vx);
      z = phase - DEG90;
    end else if (phase <= 3 * DEG90) begin
      x = -longint'(vx);
      y = -longint'(vy);
      z = phase - 2 * DEG90;
    end else begin
      x = longint'(vy);
      y = -longint'(vx);
      z = phase - 3 * DEG90;
    end
    x = x * 65536;
    y = y * 65536;
    for (int j = 0; j < crsd_pkg::STAGES_DEF && j < 24; j++) begin
      xs   = x >>> j;
      ys   = y >>> j;
      step = (ATAN_DEG_Q20[j] + 8) >>> 4;
      if (z < 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    r = (y * 39800 + (longint'(1) <<< 31)) >>> 32;
    if (r > CLAMP) r = CLAMP;
    if (r < -CLAMP) r = -CLAMP;
    return r[crsd_pkg::OUT_W-1:0];
  endfunction

  task automatic send_vector(
    input logic signed [crsd_pkg::VEC_W-1:0] vx,
    input logic signed [crsd_pkg::VEC_W-1:0] vy,
    input logic [crsd_pkg::ANGLE_W-1:0]      ang,
    input logic                              typed,
    input logic signed [crsd_pkg::OUT_W-1:0] typed_y
  );
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_vec_x     <= vx;
    in_vec_y     <= vy;
    in_angle_deg <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_y.push_back(typed ? typed_y : cordic_sine(vx, vy, ang));
    sent_count++;
  endtask

  function automatic logic signed [crsd_pkg::VEC_W-1:0] pick_component();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  initial begin
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      int hold;
      hold = out_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (checked_count % 32 == 0) out_burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_y.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("Unexpected transaction on the output: rotated_y %0d", out_rotated_y);
        end
      end else begin
        if (out_rotated_y !== pending_y[0]) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Result %0d: rotated_y expected %0d, actual %0d",
                     checked_count, pending_y[0], out_rotated_y);
          end
        end
        void'(pending_y.pop_front());
      end
      if (out_rotated_y == 17'sd46341 || out_rotated_y == -17'sd46341) clamped_count++;
      checked_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_y.size());
      $display("tb_cordic_rotate_sine_degrees failed");
      $finish;
    end
  end

  initial begin
    logic signed [crsd_pkg::VEC_W-1:0] vx;
    logic signed [crsd_pkg::VEC_W-1:0] vy;
    logic [crsd_pkg::ANGLE_W-1:0]      ang;
    int                                k;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_vec_x      = '0;
    in_vec_y      = '0;
    in_angle_deg  = '0;
    sent_count    = 0;
    checked_count = 0;
    clamped_count = 0;
    fault_count   = 0;
    idle_cycles   = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_CASES; i++) begin
      send_vector(sine_cases[i].x, sine_cases[i].y, sine_cases[i].ang,
                  sine_cases[i].typed, sine_cases[i].y_out);
    end

    for (int i = 0; i < RANDOM_N; i++) begin
      if (i % 32 == 0) in_burst = ($urandom_range(0, 3) == 0);
      vx  = crsd_pkg::VEC_W'($urandom);
      vy  = crsd_pkg::VEC_W'($urandom);
      ang = crsd_pkg::ANGLE_W'($urandom_range(0, 67108863));
      case ($urandom_range(0, 7))
        0: begin
          vx = pick_component();
          vy = pick_component();
        end
        1: begin
          k   = $urandom_range(0, 11);
          ang = crsd_pkg::ANGLE_W'(k * 5898240 +
                (k == 0 ? $urandom_range(0, 2) : $urandom_range(0, 4) - 2));
        end
        default: ;
      endcase
      send_vector(vx, vy, ang, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_y.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d vectors (%0d directed) across all quadrants, borders and wraps;",
             sent_count, N_CASES);
    $display("checked %0d results, %0d at the clamp limit, %0d mismatches.",
             checked_count, clamped_count, fault_count);
    if (fault_count == 0 && pending_y.size() == 0) begin
      $display("tb_cordic_rotate_sine_degrees passed");
    end else begin
      $display("tb_cordic_rotate_sine_degrees failed");
    end
    $finish;
  end

endmodule
